// ===== hw/rtl/md5_pkg.sv =====
// md5_pkg: shared types, microcode field codes and MD5 constant tables.
// Used by md5_seq, md5_core and md5_digest; depends on nothing else.

package md5_pkg;

  // put_sel codes: what byte the datapath writes into the block buffer
  localparam logic [1:0] PUT_NONE = 2'd0;
  localparam logic [1:0] PUT_DATA = 2'd1;
  localparam logic [1:0] PUT_MARK = 2'd2;
  localparam logic [1:0] PUT_ZERO = 2'd3;

  // jump codes of the control word
  localparam logic [3:0] J_GOTO   = 4'd0;
  localparam logic [3:0] J_ACCEPT = 4'd1;
  localparam logic [3:0] J_DATA   = 4'd2;
  localparam logic [3:0] J_LAST   = 4'd3;
  localparam logic [3:0] J_WRAP   = 4'd4;
  localparam logic [3:0] J_PAD    = 4'd5;
  localparam logic [3:0] J_CALL   = 4'd6;
  localparam logic [3:0] J_ROUND  = 4'd7;
  localparam logic [3:0] J_RET    = 4'd8;
  localparam logic [3:0] J_EMIT   = 4'd9;

  // block buffer positions
  localparam logic [5:0] PAD_END       = 6'd56;
  localparam logic [5:0] BLK_LAST_BYTE = 6'd63;
  localparam logic [3:0] BLK_LEN_LO    = 4'd14;
  localparam logic [3:0] BLK_LEN_HI    = 4'd15;
  localparam logic [5:0] ROUND_LAST    = 6'd63;
  localparam logic [63:0] BITS_PER_BYTE = 64'd8;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  // one control word of the sequencer program
  typedef struct packed {
    logic       ready;
    logic [1:0] put_sel;
    logic       len_wr;
    logic       init_work;
    logic       round1;
    logic       round2;
    logic       chain_add;
    logic       emit;
    logic       clear_msg;
    logic [3:0] jmp;
    logic [3:0] target;
  } ctrl_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic wrap;
    logic at56;
    logic last_round;
  } core_flags_t;

  typedef struct packed {
    logic        accept;
    logic        last;
    logic        emit_done;
    core_flags_t core;
  } status_t;

  // additive constant of round r
  function automatic logic [31:0] round_const(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  // left-rotate amount: depends on quarter and round mod 4
  function automatic logic [4:0] rot_amount(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
    endcase
    return s;
  endfunction

  // message word used in round r (all arithmetic mod 16)
  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] g;
    case (r[5:4])
      2'd0:    g = r[3:0];
      2'd1:    g = 4'(r[3:0] * 4'd5 + 4'd1);
      2'd2:    g = 4'(r[3:0] * 4'd3 + 4'd5);
      default: g = 4'(r[3:0] * 4'd7);
    endcase
    return g;
  endfunction

endpackage

// ===== hw/rtl/md5_digest.sv =====
// md5_digest: streaming MD5 digest top level.
// Holds the input beat and output register; instantiates md5_seq and md5_core.
//
// Usage: message bytes enter on the s_ channel, one beat each. s_tuser[0] says the
// beat carries a byte in s_tdata; s_tlast marks the final beat of a message (it may
// carry a byte or be empty). After the final beat the block pads the message and
// returns four beats on the m_ channel: chaining words A, B, C, D in m_tdata, the
// word number in m_tuser, m_tlast on D. The digest is those words, each low byte
// first.
// Flow: a byte beat passes an accept step and a buffer write step; a beat that
// completes a 64-byte block adds a compression on the shared round datapath, two
// steps per MD5 round plus load and feed-forward. A final beat adds a marker step,
// up to 64 pad steps and a length step, then one or two compressions before the
// first digest word is shown. No beat is taken until the wait step comes again.
// Reset returns the chaining words and counters to their initial values and empties
// the output register. If the receiver stalls, the output register holds its word
// and the sequencer waits; no input beat is taken until all four words are loaded.

module md5_digest
  import md5_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_message
  input  logic [0:0]  s_tuser,   // [0] byte_present
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic        m_tlast,   // last_word
  output logic [1:0]  m_tuser    // [1:0] word_number
);

  ctrl_t       ctrl;
  status_t     status;
  core_flags_t core_flags;

  logic        accept;
  logic [7:0]  hold_byte;
  logic        hold_present;
  logic        hold_last;
  logic [1:0]  word_idx;
  logic [31:0] digest_word;
  logic        emit_fire;

  // no beat is taken while reset is held
  assign s_tready  = ctrl.ready && !rst;
  assign accept    = s_tvalid && s_tready;
  assign emit_fire = ctrl.emit && (!m_tvalid || m_tready);

  // input beat holding register
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_byte    <= s_tdata;
      hold_present <= s_tuser[0];
      hold_last    <= s_tlast;
    end
  end

  // output register and word counter
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      word_idx <= '0;
    end else if (emit_fire) begin
      m_tvalid <= 1'b1;
      word_idx <= word_idx + 2'd1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      m_tdata <= digest_word;
      m_tuser <= word_idx;
      m_tlast <= (word_idx == 2'd3);
    end
  end

  assign status.accept    = accept;
  assign status.last      = hold_last;
  assign status.emit_done = emit_fire && (word_idx == 2'd3);
  assign status.core      = core_flags;

  md5_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  md5_core u_core (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .byte_in      (hold_byte),
    .byte_present (hold_present),
    .word_sel     (word_idx),
    .digest_word  (digest_word),
    .flags        (core_flags)
  );

endmodule

// ===== hw/rtl/md5_core.sv =====
// md5_core: block buffer, chaining words, message counters and the round datapath.
// Driven by control words from md5_seq; uses md5_pkg.

module md5_core
  import md5_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  ctrl_t       ctrl,
  input  logic [7:0]  byte_in,
  input  logic        byte_present,
  input  logic [1:0]  word_sel,
  output logic [31:0] digest_word,
  output core_flags_t flags
);

  logic [31:0] blk [16];
  logic [31:0] chain [4];
  logic [31:0] a, b, c, d, tmp;
  logic [5:0]  rnd;
  logic [5:0]  pos;
  logic [63:0] bit_count;

  logic        put_en;
  logic [7:0]  put_val;
  logic [31:0] f;
  logic [63:0] rot_dbl;

  // byte source for the buffer write
  always_comb begin
    put_en  = 1'b0;
    put_val = 8'h00;
    case (ctrl.put_sel)
      PUT_DATA: begin
        put_en  = byte_present;
        put_val = byte_in;
      end
      PUT_MARK: begin
        put_en  = 1'b1;
        put_val = 8'h80;
      end
      PUT_ZERO: begin
        put_en  = (pos != PAD_END);
        put_val = 8'h00;
      end
      default: begin
        put_en  = 1'b0;
        put_val = 8'h00;
      end
    endcase
  end

  // round function by quarter
  always_comb begin
    case (rnd[5:4])
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (d & b) | (~d & c);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
  end

  assign rot_dbl = {tmp, tmp} << rot_amount(rnd);

  // block buffer: little-endian byte lanes, lane 0 clears the word
  always_ff @(posedge clk) begin
    if (put_en) begin
      if (pos[1:0] == 2'd0) begin
        blk[pos[5:2]] <= {24'h0, put_val};
      end else begin
        blk[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= put_val;
      end
    end
    if (ctrl.len_wr) begin
      blk[BLK_LEN_LO] <= bit_count[31:0];
      blk[BLK_LEN_HI] <= bit_count[63:32];
    end
  end

  // message position, length and chaining words
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear_msg) begin
      pos       <= '0;
      bit_count <= '0;
      chain[0]  <= INIT_A;
      chain[1]  <= INIT_B;
      chain[2]  <= INIT_C;
      chain[3]  <= INIT_D;
    end else begin
      if (put_en) pos <= pos + 6'd1;
      if (ctrl.put_sel == PUT_DATA && byte_present) bit_count <= bit_count + BITS_PER_BYTE;
      if (ctrl.chain_add) begin
        chain[0] <= chain[0] + a;
        chain[1] <= chain[1] + b;
        chain[2] <= chain[2] + c;
        chain[3] <= chain[3] + d;
      end
    end
  end

  // round counter
  always_ff @(posedge clk) begin
    if (rst) begin
      rnd <= '0;
    end else if (ctrl.init_work) begin
      rnd <= '0;
    end else if (ctrl.round2) begin
      rnd <= rnd + 6'd1;
    end
  end

  // working registers: half a round per step
  always_ff @(posedge clk) begin
    if (ctrl.init_work) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
    end
    if (ctrl.round1) begin
      tmp <= a + f + round_const(rnd) + blk[msg_index(rnd)];
    end
    if (ctrl.round2) begin
      a <= d;
      b <= b + rot_dbl[63:32];
      c <= b;
      d <= c;
    end
  end

  assign digest_word      = chain[word_sel];
  assign flags.wrap       = put_en && (pos == BLK_LAST_BYTE);
  assign flags.at56       = (pos == PAD_END);
  assign flags.last_round = (rnd == ROUND_LAST);

`ifndef NO_ASSERTIONS
  // the feed-forward add follows the 64th round, when the counter has wrapped
  a_add_after_rounds: assert property (@(posedge clk) disable iff (rst)
    ctrl.chain_add |-> rnd == 6'd0)
    else $error("chain add with round counter not wrapped");

  // length words land only in a buffer padded up to byte 56
  a_len_at_pad_end: assert property (@(posedge clk) disable iff (rst)
    ctrl.len_wr |-> pos == PAD_END)
    else $error("length written at wrong buffer position");
`endif

endmodule

// ===== hw/rtl/md5_seq.sv =====
// md5_seq: step counter, return register and microcode table of the MD5 block.
// Issues one control word per step to md5_core and md5_digest; uses md5_pkg.

module md5_seq
  import md5_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output ctrl_t   ctrl
);

  // program steps
  localparam logic [3:0] STEP_WAIT   = 4'd0;
  localparam logic [3:0] STEP_DATA   = 4'd1;
  localparam logic [3:0] STEP_CHK    = 4'd2;
  localparam logic [3:0] STEP_MARK   = 4'd3;
  localparam logic [3:0] STEP_PAD    = 4'd4;
  localparam logic [3:0] STEP_LEN    = 4'd5;
  localparam logic [3:0] STEP_EMIT   = 4'd6;
  localparam logic [3:0] STEP_CLEAR  = 4'd7;
  localparam logic [3:0] STEP_C_INIT = 4'd8;
  localparam logic [3:0] STEP_C_R1   = 4'd9;
  localparam logic [3:0] STEP_C_R2   = 4'd10;
  localparam logic [3:0] STEP_C_ADD  = 4'd11;

  logic [3:0] pc, pc_next;
  logic [3:0] ret, ret_next;
  ctrl_t      uw;

  // microcode ROM
  function automatic ctrl_t ucode(input logic [3:0] step);
    ctrl_t w;
    w = '0;
    unique case (step)
      STEP_WAIT:   begin w.ready = 1'b1;        w.jmp = J_ACCEPT; w.target = STEP_DATA;  end
      STEP_DATA:   begin w.put_sel = PUT_DATA;  w.jmp = J_DATA;   w.target = STEP_CHK;   end
      STEP_CHK:    begin                        w.jmp = J_LAST;   w.target = STEP_MARK;  end
      STEP_MARK:   begin w.put_sel = PUT_MARK;  w.jmp = J_WRAP;   w.target = STEP_PAD;   end
      STEP_PAD:    begin w.put_sel = PUT_ZERO;  w.jmp = J_PAD;    w.target = STEP_LEN;   end
      STEP_LEN:    begin w.len_wr = 1'b1;       w.jmp = J_CALL;   w.target = STEP_EMIT;  end
      STEP_EMIT:   begin w.emit = 1'b1;         w.jmp = J_EMIT;   w.target = STEP_CLEAR; end
      STEP_CLEAR:  begin w.clear_msg = 1'b1;    w.jmp = J_GOTO;   w.target = STEP_WAIT;  end
      STEP_C_INIT: begin w.init_work = 1'b1;    w.jmp = J_GOTO;   w.target = STEP_C_R1;  end
      STEP_C_R1:   begin w.round1 = 1'b1;       w.jmp = J_GOTO;   w.target = STEP_C_R2;  end
      STEP_C_R2:   begin w.round2 = 1'b1;       w.jmp = J_ROUND;  w.target = STEP_C_ADD; end
      STEP_C_ADD:  begin w.chain_add = 1'b1;    w.jmp = J_RET;    w.target = STEP_WAIT;  end
      default:     begin                        w.jmp = J_GOTO;   w.target = STEP_WAIT;  end
    endcase
    return w;
  endfunction

  assign uw   = ucode(pc);
  assign ctrl = uw;

  // next step; a call saves the return step and enters the compression routine
  always_comb begin
    pc_next  = pc;
    ret_next = ret;
    unique case (uw.jmp)
      J_GOTO:   pc_next = uw.target;
      J_ACCEPT: pc_next = status.accept ? uw.target : pc;
      J_DATA: begin
        if (status.core.wrap) begin
          ret_next = uw.target;
          pc_next  = STEP_C_INIT;
        end else begin
          pc_next = status.last ? STEP_MARK : STEP_WAIT;
        end
      end
      J_LAST:   pc_next = status.last ? uw.target : STEP_WAIT;
      J_WRAP: begin
        if (status.core.wrap) begin
          ret_next = uw.target;
          pc_next  = STEP_C_INIT;
        end else begin
          pc_next = uw.target;
        end
      end
      J_PAD: begin
        if (status.core.at56) begin
          pc_next = uw.target;
        end else if (status.core.wrap) begin
          ret_next = pc;
          pc_next  = STEP_C_INIT;
        end
      end
      J_CALL: begin
        ret_next = uw.target;
        pc_next  = STEP_C_INIT;
      end
      J_ROUND:  pc_next = status.core.last_round ? uw.target : STEP_C_R1;
      J_RET:    pc_next = ret;
      J_EMIT:   pc_next = status.emit_done ? uw.target : pc;
      default:  pc_next = STEP_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= STEP_WAIT;
      ret <= STEP_WAIT;
    end else begin
      pc  <= pc_next;
      ret <= ret_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    pc <= STEP_C_ADD)
    else $error("step counter outside program");

  // compression is entered only from a step that fills or closes a block
  a_call_site: assert property (@(posedge clk) disable iff (rst)
    pc == STEP_C_INIT |-> $past(pc) == STEP_DATA || $past(pc) == STEP_MARK ||
                          $past(pc) == STEP_PAD || $past(pc) == STEP_LEN)
    else $error("compression entered from unexpected step");

  // the routine always returns to a step that expects it
  a_ret_valid: assert property (@(posedge clk) disable iff (rst)
    pc == STEP_C_ADD |-> ret == STEP_CHK || ret == STEP_PAD || ret == STEP_EMIT)
    else $error("bad return step");
`endif

endmodule
